### hdl/akt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator knob tuner package
// Shared widths, reset values, register indexes, action codes and the
// structs passed between the tuner's sub-blocks.
// ----------------------------------------------------------------------------
package akt_pkg;

    localparam int NUM_CLASSES     = 32;
    localparam int INIT_BIN_TARGET = 0;
    localparam int INIT_BATCH      = 8;

    localparam int CLASS_W    = 5;
    localparam int COUNT_W    = 32;
    localparam int BIN_W      = 8;
    localparam int BATCH_W    = 5;
    localparam int ACT_W      = 2;
    localparam int VER_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // table index width
    localparam int IDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_CAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_CAP  = 3'd4;

    // register reset values
    localparam logic [COUNT_W-1:0] RST_REFILL_THR = 32'd100;
    localparam logic [COUNT_W-1:0] RST_TRIM_THR   = 32'd50;
    localparam logic [COUNT_W-1:0] RST_MISS_THR   = 32'd20;
    localparam logic [BIN_W-1:0]   RST_BIN_CAP    = 8'd64;
    localparam logic [BATCH_W-1:0] RST_BATCH_CAP  = 5'd16;

    typedef logic [ACT_W-1:0] action_t;

    localparam action_t ACT_NONE      = 2'd0;
    localparam action_t ACT_BIN_UP    = 2'd1;
    localparam action_t ACT_BIN_DOWN  = 2'd2;
    localparam action_t ACT_BATCH_UP  = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] refill_thr;
        logic [COUNT_W-1:0] trim_thr;
        logic [COUNT_W-1:0] miss_thr;
        logic [BIN_W-1:0]   bin_cap;
        logic [BATCH_W-1:0] batch_cap;
    } cfg_t;

    typedef struct packed {
        logic [CLASS_W-1:0] size_class;
        logic [COUNT_W-1:0] refill_count;
        logic [COUNT_W-1:0] trim_excess;
        logic [COUNT_W-1:0] pop_misses;
        logic               epoch_end;
    } item_t;

    // epoch winner with its threshold tests already resolved
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic               refill_hi;
        logic               trim_hi;
        logic               miss_hi;
    } winner_t;

    typedef struct packed {
        logic [CLASS_W-1:0] chosen_class;
        action_t            action;
        logic [BIN_W-1:0]   new_value;
        logic [VER_W-1:0]   version;
    } result_t;

endpackage

### hdl/akt_intake.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner input register
// Holds one accepted statistics item until the processing stage takes it.
// ----------------------------------------------------------------------------
module akt_intake
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  akt_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output akt_pkg::item_t item
);
    import akt_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hdl/akt_argmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner epoch argmax
// Running maximum on refill count over one epoch; earlier item wins a tie.
// ----------------------------------------------------------------------------
module akt_argmax
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  akt_pkg::item_t   item,
    input  akt_pkg::cfg_t    cfg,
    output akt_pkg::winner_t winner
);
    import akt_pkg::*;

    logic [COUNT_W-1:0] best_refills_reg;
    logic [COUNT_W-1:0] best_trim_reg;
    logic [COUNT_W-1:0] best_misses_reg;
    logic [CLASS_W-1:0] best_class_reg;
    logic               have_best_reg;

    logic    in_range;
    logic    take;
    winner_t cand_w;
    winner_t best_w;

    assign in_range = int'(item.size_class) < NUM_CLASSES;
    assign take     = in_range && (!have_best_reg || (item.refill_count > best_refills_reg));

    // threshold tests on both sides in parallel, then select
    always_comb
    begin
        cand_w.cls       = item.size_class;
        cand_w.refill_hi = item.refill_count > cfg.refill_thr;
        cand_w.trim_hi   = item.trim_excess > cfg.trim_thr;
        cand_w.miss_hi   = item.pop_misses > cfg.miss_thr;
        best_w.cls       = best_class_reg;
        best_w.refill_hi = best_refills_reg > cfg.refill_thr;
        best_w.trim_hi   = best_trim_reg > cfg.trim_thr;
        best_w.miss_hi   = best_misses_reg > cfg.miss_thr;
    end

    assign winner = take ? cand_w : best_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_refills_reg <= '0;
            best_trim_reg    <= '0;
            best_misses_reg  <= '0;
            best_class_reg   <= '0;
            have_best_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (item.epoch_end)
            begin
                best_refills_reg <= '0;
                best_trim_reg    <= '0;
                best_misses_reg  <= '0;
                best_class_reg   <= '0;
                have_best_reg    <= 1'b0;
            end
            else if (take)
            begin
                best_refills_reg <= item.refill_count;
                best_trim_reg    <= item.trim_excess;
                best_misses_reg  <= item.pop_misses;
                best_class_reg   <= item.size_class;
                have_best_reg    <= 1'b1;
            end
        end
    end

endmodule

### hdl/akt_knobs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tuner knob tables
// Per-class bin target and refill batch, the epoch-end rule and the version
// counter.
// ----------------------------------------------------------------------------
module akt_knobs
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             apply,
    input  akt_pkg::winner_t winner,
    input  akt_pkg::cfg_t    cfg,
    output akt_pkg::result_t result
);
    import akt_pkg::*;

    logic [BIN_W-1:0]   bin_level_reg  [NUM_CLASSES];
    logic [BATCH_W-1:0] batch_reg      [NUM_CLASSES];
    logic [VER_W-1:0]   version_reg;

    logic [IDX_W-1:0]   idx;
    logic [BIN_W-1:0]   cur_bin;
    logic [BATCH_W-1:0] cur_batch;
    logic [BIN_W-1:0]   bin_next;
    logic [BATCH_W-1:0] batch_next;
    logic [VER_W-1:0]   version_next;
    action_t            act;
    logic [BIN_W-1:0]   new_value;

    assign idx       = winner.cls[IDX_W-1:0];
    assign cur_bin   = bin_level_reg[idx];
    assign cur_batch = batch_reg[idx];

    // at most one change, in priority order
    always_comb
    begin
        act        = ACT_NONE;
        bin_next   = cur_bin;
        batch_next = cur_batch;
        new_value  = cur_bin;
        if (winner.refill_hi && (cur_bin < cfg.bin_cap))
        begin
            act       = ACT_BIN_UP;
            bin_next  = cur_bin + 1'b1;
            new_value = bin_next;
        end
        else if (winner.trim_hi && (cur_bin != '0))
        begin
            act       = ACT_BIN_DOWN;
            bin_next  = cur_bin - 1'b1;
            new_value = bin_next;
        end
        else if (winner.miss_hi && (cur_batch < cfg.batch_cap))
        begin
            act        = ACT_BATCH_UP;
            batch_next = cur_batch + 1'b1;
            new_value  = BIN_W'(batch_next);
        end
    end

    assign version_next = (act != ACT_NONE) ? version_reg + 1'b1 : version_reg;

    always_comb
    begin
        result.chosen_class = winner.cls;
        result.action       = act;
        result.new_value    = new_value;
        result.version      = version_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                bin_level_reg[i] <= BIN_W'(INIT_BIN_TARGET);
                batch_reg[i]     <= BATCH_W'(INIT_BATCH);
            end
            version_reg <= '0;
        end
        else if (apply)
        begin
            bin_level_reg[idx] <= bin_next;
            batch_reg[idx]     <= batch_next;
            version_reg        <= version_next;
        end
    end

endmodule

### hdl/allocator_knob_tuner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator knob tuner
// Per-epoch refill-call argmax and at most one knob change for the winning class.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one statistics transaction per size
//    class, ascending, epoch_end set on the last one of the epoch.
//  - Output channel (out_valid/out_ready): one result transaction per epoch,
//    produced only by the epoch_end item; other items yield nothing.
//  - Config port: cfg_wr_en/cfg_addr/cfg_wdata writes a register; only to be
//    used while the block is idle. Unknown indexes ignored.
//  - Path: an item is registered at acceptance and processed from the input
//    register; the epoch_end item's result goes to the output register.
//  - Throughput: one item per cycle unless an epoch_end item is held by a full
//    output register; set by the single processing stage (argmax compare plus
//    one knob-table read-modify-write).  Stall: a finished result waits in the
//    output register; non-final items keep flowing. Only a second epoch_end
//    item holds until the first result is taken (in_ready drops once the input
//    register is full).  Reset: thresholds and caps to defaults, knob tables to
//    their initial values, version to zero, epoch tracking cleared, no result pending.
// ----------------------------------------------------------------------------
module allocator_knob_tuner
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_wr_en,
    input  logic [akt_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [akt_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [akt_pkg::CLASS_W-1:0]        size_class,
    input  logic [akt_pkg::COUNT_W-1:0]        refill_count,
    input  logic [akt_pkg::COUNT_W-1:0]        trim_excess,
    input  logic [akt_pkg::COUNT_W-1:0]        pop_misses,
    input  logic                               epoch_end,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [akt_pkg::CLASS_W-1:0]        chosen_class,
    output logic [akt_pkg::ACT_W-1:0]          action,
    output logic [akt_pkg::BIN_W-1:0]          new_value,
    output logic [akt_pkg::VER_W-1:0]          version
);
    import akt_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    apply;
    winner_t winner;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.refill_thr <= RST_REFILL_THR;
            cfg_reg.trim_thr   <= RST_TRIM_THR;
            cfg_reg.miss_thr   <= RST_MISS_THR;
            cfg_reg.bin_cap    <= RST_BIN_CAP;
            cfg_reg.batch_cap  <= RST_BATCH_CAP;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_REFILL_THR: cfg_reg.refill_thr <= cfg_wdata[COUNT_W-1:0];
                REG_TRIM_THR:   cfg_reg.trim_thr   <= cfg_wdata[COUNT_W-1:0];
                REG_MISS_THR:   cfg_reg.miss_thr   <= cfg_wdata[COUNT_W-1:0];
                REG_BIN_CAP:    cfg_reg.bin_cap    <= cfg_wdata[BIN_W-1:0];
                REG_BATCH_CAP:  cfg_reg.batch_cap  <= cfg_wdata[BATCH_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---- input register ----
    always_comb
    begin
        in_item.size_class   = size_class;
        in_item.refill_count = refill_count;
        in_item.trim_excess  = trim_excess;
        in_item.pop_misses   = pop_misses;
        in_item.epoch_end    = epoch_end;
    end

    akt_intake u_intake
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Non-final items always move on; a final one needs room in the
    // output register (empty, or being drained this cycle).
    assign advance = item_valid && (!item.epoch_end || !out_valid_reg || out_ready);
    assign apply   = advance && item.epoch_end;

    // ---- processing stage ----
    akt_argmax u_argmax
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg_reg),
        .winner  (winner)
    );

    akt_knobs u_knobs
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .apply  (apply),
        .winner (winner),
        .cfg    (cfg_reg),
        .result (result)
    );

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (apply)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chosen_class = result_reg.chosen_class;
    assign action       = result_reg.action;
    assign new_value    = result_reg.new_value;
    assign version      = result_reg.version;

endmodule
